FILE: design/multi_queue_byte_ring_buffer_defines.svh
// Assertion helpers used by the top-level design file.
`ifndef MULTI_QUEUE_BYTE_RING_BUFFER_DEFINES_SVH
`define MULTI_QUEUE_BYTE_RING_BUFFER_DEFINES_SVH

// Clocked check, off while reset is held.
`define MQBRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MQBRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mqbrb_pkg.sv
package mqbrb_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int CMD_W  = 2;
    localparam int QIDX_W = 4;
    localparam int DATA_W = 8;
    localparam int POS_W  = 4;

    localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;

    // per-transaction status, everything but the dequeued byte
    typedef struct packed {
        logic             ok;
        logic             deq;
        logic             empty;
        logic             full;
        logic [POS_W-1:0] front;
        logic [POS_W-1:0] rear;
    } t_status;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_op;

endpackage

FILE: design/multi_queue_byte_ring_buffer.sv
// Several circular byte queues sharing one byte memory. Each transaction
// names a queue and enqueues, dequeues or just reads status; one result comes
// back per transaction. A new transaction is taken every cycle while the
// result register is free or being drained, so sustained rate is one per
// clock. The result appears in the cycle after acceptance: the front/rear
// pointer table is read and updated in the accept cycle, and the dequeued
// byte comes from the memory's registered read port loaded on that same
// edge. No clearing pass after reset; only the pointer table and result valid flag are reset.
module multi_queue_byte_ring_buffer #(
    parameter int NUM_QUEUES  = mqbrb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqbrb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mqbrb_pkg::CMD_W-1:0]   i_cmd,
    input  logic [mqbrb_pkg::QIDX_W-1:0]  i_q_index,
    input  logic [mqbrb_pkg::DATA_W-1:0]  i_data_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_ok,
    output logic [mqbrb_pkg::DATA_W-1:0]  o_data_out,
    output logic                          o_is_empty,
    output logic                          o_is_full,
    output logic [mqbrb_pkg::POS_W-1:0]   o_front_pos,
    output logic [mqbrb_pkg::POS_W-1:0]   o_rear_pos
);
    import mqbrb_pkg::*;
    `include "multi_queue_byte_ring_buffer_defines.svh"

    localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic              in_acc;
    t_status           status;
    t_mem_op           mem_op;
    logic [AW-1:0]     addr;
    logic [DATA_W-1:0] rdata;

    logic              r_valid;
    t_status           r_res;

    assign o_ready = !r_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    mqbrb_ctrl #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (in_acc),
        .i_cmd     (i_cmd),
        .i_q_index (i_q_index),
        .o_status  (status),
        .o_mem_op  (mem_op),
        .o_addr    (addr)
    );

    mqbrb_store #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_op    (mem_op),
        .i_addr  (addr),
        .i_wdata (i_data_in),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_acc) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= status;
        end
    end

    assign o_valid     = r_valid;
    assign o_ok        = r_res.ok;
    // read register only loads on a successful dequeue
    assign o_data_out  = r_res.deq ? rdata : '0;
    assign o_is_empty  = r_res.empty;
    assign o_is_full   = r_res.full;
    assign o_front_pos = r_res.front;
    assign o_rear_pos  = r_res.rear;

    `MQBRB_ASSERT(a_acc_gives_result, i_clk, i_rst_n, in_acc |=> o_valid, "accepted transaction produced no result")
    `MQBRB_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (o_valid && o_is_empty) |-> (o_front_pos == o_rear_pos), "empty flag with unequal pointers")
    `MQBRB_ASSERT(a_flags_excl, i_clk, i_rst_n, o_valid |-> !(o_is_empty && o_is_full), "queue reported empty and full")
    `MQBRB_ASSERT(a_data_only_deq, i_clk, i_rst_n, (o_valid && !r_res.deq) |-> (o_data_out == '0), "data on a non-dequeue result")
    `MQBRB_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

FILE: design/mqbrb_store.sv
module mqbrb_store #(
    parameter int NUM_QUEUES  = mqbrb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqbrb_pkg::QUEUE_DEPTH_DEF,
    localparam int ENTRIES    = NUM_QUEUES * QUEUE_DEPTH,
    localparam int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  mqbrb_pkg::t_mem_op            i_op,
    input  logic [AW-1:0]                 i_addr,
    input  logic [mqbrb_pkg::DATA_W-1:0]  i_wdata,
    output logic [mqbrb_pkg::DATA_W-1:0]  o_rdata
);
    import mqbrb_pkg::*;

    logic [DATA_W-1:0] r_mem [ENTRIES];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_op.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_op.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mqbrb_ctrl.sv
module mqbrb_ctrl #(
    parameter int NUM_QUEUES  = mqbrb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqbrb_pkg::QUEUE_DEPTH_DEF,
    localparam int ENTRIES    = NUM_QUEUES * QUEUE_DEPTH,
    localparam int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [mqbrb_pkg::CMD_W-1:0]   i_cmd,
    input  logic [mqbrb_pkg::QIDX_W-1:0]  i_q_index,
    output mqbrb_pkg::t_status            o_status,
    output mqbrb_pkg::t_mem_op            o_mem_op,
    output logic [AW-1:0]                 o_addr
);
    import mqbrb_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(QUEUE_DEPTH - 1);

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        next_pos = (p == LAST_POS) ? '0 : p + PW'(1);
    endfunction

    logic [PW-1:0] r_front [NUM_QUEUES];
    logic [PW-1:0] r_rear  [NUM_QUEUES];

    logic          q_ok;
    logic [QW-1:0] qi;
    logic [PW-1:0] cur_front, cur_rear, inc_front, inc_rear;
    logic [PW-1:0] n_front, n_rear, slot;
    t_status       status;
    t_mem_op       mem_op;

    assign q_ok      = {1'b0, i_q_index} < (QIDX_W + 1)'(NUM_QUEUES);
    assign qi        = i_q_index[QW-1:0];
    assign cur_front = r_front[qi];
    assign cur_rear  = r_rear[qi];
    assign inc_front = next_pos(cur_front);
    assign inc_rear  = next_pos(cur_rear);

    always_comb begin
        n_front = cur_front;
        n_rear  = cur_rear;
        status  = '0;
        mem_op  = '0;
        slot    = inc_front;
        if (q_ok) begin
            unique case (i_cmd)
                CMD_ENQ: begin
                    slot = inc_rear;
                    if (inc_rear != cur_front) begin
                        n_rear    = inc_rear;
                        status.ok = 1'b1;
                        mem_op.we = i_go;
                    end
                end
                CMD_DEQ: begin
                    if (cur_front != cur_rear) begin
                        n_front    = inc_front;
                        status.ok  = 1'b1;
                        status.deq = 1'b1;
                        mem_op.re  = i_go;
                    end
                end
                default: begin
                    status.ok = 1'b1;
                end
            endcase
            status.empty = (n_front == n_rear);
            status.full  = (next_pos(n_rear) == n_front);
            status.front = POS_W'(n_front);
            status.rear  = POS_W'(n_rear);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_front[i] <= '0;
                r_rear[i]  <= '0;
            end
        end else if (i_go && q_ok) begin
            r_front[qi] <= n_front;
            r_rear[qi]  <= n_rear;
        end
    end

    assign o_status = status;
    assign o_mem_op = mem_op;
    // queue base plus slot; multiply is by a constant
    assign o_addr   = AW'(32'(qi) * 32'(QUEUE_DEPTH) + 32'(slot));

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mqbrb_pkg::*;

    localparam int NQ             = NUM_QUEUES_DEF;
    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 925;
    localparam int QUIET_FROM     = 780;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [CMD_W-1:0] CMD_STAT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data;
        logic              empty;
        logic              full;
        logic [POS_W-1:0]  front;
        logic [POS_W-1:0]  rear;
    } t_ring_result;

    // Tracks pointer tables and byte store, queues one expected result per transaction.
    class t_ring_scoreboard;
        logic [POS_W-1:0]  front_tbl[NQ];
        logic [POS_W-1:0]  rear_tbl[NQ];
        logic [DATA_W-1:0] byte_mem[NQ*DEPTH];
        t_ring_result      expected_q[$];
        int                errors;

        function new();
            foreach (front_tbl[i]) begin
                front_tbl[i] = '0;
                rear_tbl[i]  = '0;
            end
            errors = 0;
        endfunction

        function logic [POS_W-1:0] wrap_inc(logic [POS_W-1:0] p);
            return POS_W'((int'(p) + 1) % DEPTH);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_cmd(logic [CMD_W-1:0] cmd, logic [QIDX_W-1:0] q,
                               logic [DATA_W-1:0] din);
            t_ring_result r;
            r = '0;
            if (int'(q) < NQ) begin
                r.front = front_tbl[q];
                r.rear  = rear_tbl[q];
                if (cmd == CMD_ENQ) begin
                    if (wrap_inc(r.rear) != r.front) begin
                        r.rear = wrap_inc(r.rear);
                        rear_tbl[q] = r.rear;
                        byte_mem[int'(q) * DEPTH + int'(r.rear)] = din;
                        r.ok = 1'b1;
                    end
                end else if (cmd == CMD_DEQ) begin
                    if (r.front != r.rear) begin
                        r.front = wrap_inc(r.front);
                        front_tbl[q] = r.front;
                        r.data = byte_mem[int'(q) * DEPTH + int'(r.front)];
                        r.ok = 1'b1;
                    end
                end else begin
                    // status query and the unused code behave the same
                    r.ok = 1'b1;
                end
                r.empty = (r.front == r.rear);
                r.full  = (wrap_inc(r.rear) == r.front);
            end
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_ring_result got);
            t_ring_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending: ok %0b data %02h", got.ok,
                                 got.data));
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
                report($sformatf({"got/exp ok %0b/%0b data %02h/%02h empty %0b/%0b ",
                                  "full %0b/%0b front %0d/%0d rear %0d/%0d"},
                                 got.ok, want.ok, got.data, want.data, got.empty,
                                 want.empty, got.full, want.full, got.front, want.front,
                                 got.rear, want.rear));
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic [CMD_W-1:0]  i_cmd       = '0;
    logic [QIDX_W-1:0] i_q_index   = '0;
    logic [DATA_W-1:0] i_data_in   = '0;
    logic              i_ready     = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_ok;
    logic [DATA_W-1:0] o_data_out;
    logic              o_is_empty;
    logic              o_is_full;
    logic [POS_W-1:0]  o_front_pos;
    logic [POS_W-1:0]  o_rear_pos;

    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;

    t_ring_scoreboard sb = new();

    multi_queue_byte_ring_buffer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_q_index   (i_q_index),
        .i_data_in   (i_data_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_ok        (o_ok),
        .o_data_out  (o_data_out),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_front_pos (o_front_pos),
        .o_rear_pos  (o_rear_pos)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [QIDX_W-1:0] q,
                            input logic [DATA_W-1:0] din);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_q_index <= q;
        i_data_in <= din;
        do @(posedge i_clk); while (!o_ready);
        sb.note_cmd(cmd, q, din);
    endtask

    task automatic idle_gap(input int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 5));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                hold--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                hold = $urandom_range(0, 4);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_ok, o_data_out, o_is_empty, o_is_full, o_front_pos,
                              o_rear_pos});
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int focus;
        int enq_pct;
        int pick;
        logic [CMD_W-1:0]  cmd;
        logic [QIDX_W-1:0] q;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, every command, empty and invalid queues
        send_cmd(CMD_ENQ, 0, 8'h00);
        send_cmd(CMD_ENQ, 0, 8'hFF);
        send_cmd(CMD_STAT, 0, 8'hA5);
        maybe_idle();
        send_cmd(CMD_RSVD, 0, 8'h5A);
        send_cmd(CMD_DEQ, 0, 8'h00);
        send_cmd(CMD_DEQ, 0, 8'h00);
        send_cmd(CMD_DEQ, 0, 8'hFF);
        send_cmd(CMD_ENQ, QIDX_W'(NQ), 8'h11);
        send_cmd(CMD_DEQ, 4'hF, 8'h22);
        send_cmd(CMD_STAT, 4'hF, 8'h33);
        // fill the last queue to the brim, then one enqueue too many
        for (int i = 0; i < DEPTH; i++) begin
            send_cmd(CMD_ENQ, QIDX_W'(NQ - 1), DATA_W'($urandom_range(0, 255)));
            maybe_idle();
        end
        wait_drained();

        focus   = 0;
        enq_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 60 == 0) begin
                focus = $urandom_range(0, NQ - 1);
                case ($urandom_range(0, 2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
            end
            if (i == QUIET_FROM) quiet = 1'b1;
            if (i == 300) long_hold_req = 1'b1;
            if (i == 520) wait_drained();

            pick = $urandom_range(0, 99);
            if (pick < 65)      q = QIDX_W'(focus);
            else if (pick < 92) q = QIDX_W'($urandom_range(0, NQ - 1));
            else                q = QIDX_W'($urandom_range(NQ, 15));

            if ($urandom_range(0, 99) < 90)
                cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            else
                cmd = ($urandom_range(0, 1) == 0) ? CMD_STAT : CMD_RSVD;

            send_cmd(cmd, q, DATA_W'($urandom_range(0, 255)));
            maybe_idle();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
